@@ design/page_frame_allocator_unit_assert.svh @@
// Assertion macros used by the checker of the page frame allocator.
`ifndef PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define PFA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define PFA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/pfa_pkg.sv @@
// Shared types and constants of the page frame allocator.
package pfa_pkg;

    localparam int FRAMES_DEF = 64;

    localparam int PSZ_W   = 12;
    localparam int CNT_W   = 7;
    localparam int ID_W    = 8;
    localparam int BYTES_W = 18;
    localparam int NOW_W   = 17;
    localparam int SUM_W   = 32;
    localparam int ENTRY_W = ID_W + CNT_W;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    localparam logic [BYTES_W-1:0] FREE_MAX        = 18'h3FFFF;
    localparam logic [PSZ_W-1:0]   PAGE_SIZE_RST   = 12'd100;
    localparam logic [CNT_W-1:0]   FRAME_COUNT_RST = 7'd64;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 8'd1;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    typedef struct packed {
        logic               action;
        logic [ID_W-1:0]    proc_id;
        logic [BYTES_W-1:0] mem_bytes;
        logic [NOW_W-1:0]   now;
    } pfa_req_t;

    typedef struct packed {
        logic                    status;
        logic [CNT_W-1:0]        frames_changed;
        logic [BYTES_W-1:0]      free_bytes;
        logic signed [SUM_W-1:0] turnaround_sum;
    } pfa_res_t;

    typedef struct packed {
        logic             restart;
        logic [PSZ_W-1:0] page_size;
        logic [CNT_W-1:0] active_frames;
    } pfa_cfg_t;

endpackage

@@ design/pfa_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/pfa_engine.sv @@
// Table sequencer: clearing sweep, read-modify-write scan of the frame table, counters.
module pfa_engine
    import pfa_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  pfa_cfg_t cfg,
    input  logic     req_valid,
    output logic     req_ready,
    input  pfa_req_t req,
    output logic     res_valid,
    input  logic     res_ready,
    output pfa_res_t res
);

    localparam int AW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int IW   = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam int REMW = BYTES_W + 2;
    localparam int PRDW = CNT_W + PSZ_W;
    localparam logic [IW-1:0] LAST = IW'(FRAMES - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [AW-1:0]          paddr_reg, paddr_next;
    pfa_req_t               req_reg, req_next;
    logic signed [REMW-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]       page_reg, page_next;
    logic [CNT_W-1:0]       changed_reg, changed_next;
    logic                   status_reg, status_next;
    logic [BYTES_W-1:0]     free_reg, free_next;
    logic [SUM_W-1:0]       turn_reg, turn_next;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic [ID_W-1:0]    owner;
    logic               issue;
    logic               rem_pos;
    logic               claim;
    logic               release_hit;
    logic [PRDW-1:0]    total;
    logic [BYTES_W-1:0] load_free;
    logic [BYTES_W:0]   free_sum;
    logic [BYTES_W-1:0] free_add;
    logic [BYTES_W-1:0] free_sub;

    pfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FRAMES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign owner       = rdata[ENTRY_W-1:CNT_W];
    assign issue       = (state_reg == S_SCAN) && (idx_reg < IW'(cfg.active_frames));
    assign rem_pos     = !rem_reg[REMW-1] && (rem_reg != '0);
    assign claim       = pend_reg && (req_reg.action == ACT_ALLOC)
                         && (owner == '0) && rem_pos;
    assign release_hit = pend_reg && (req_reg.action == ACT_RELEASE)
                         && (owner == req_reg.proc_id);

    assign total     = PRDW'(cfg.active_frames) * PRDW'(cfg.page_size);
    assign load_free = (total > PRDW'(FREE_MAX)) ? FREE_MAX : total[BYTES_W-1:0];
    assign free_sum  = {1'b0, free_reg} + (BYTES_W + 1)'(cfg.page_size);
    assign free_add  = (free_sum > {1'b0, FREE_MAX}) ? FREE_MAX : free_sum[BYTES_W-1:0];
    assign free_sub  = (free_reg >= BYTES_W'(cfg.page_size))
                       ? free_reg - BYTES_W'(cfg.page_size) : '0;

    always_comb
    begin
        we    = 1'b0;
        waddr = paddr_reg;
        wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = idx_reg[AW-1:0];
        end
        else if (state_reg == S_SCAN)
        begin
            we = claim || release_hit;
            if (claim)
            begin
                wdata = {req_reg.proc_id, page_reg};
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        paddr_next   = paddr_reg;
        req_next     = req_reg;
        rem_next     = rem_reg;
        page_next    = page_reg;
        changed_next = changed_reg;
        status_next  = status_reg;
        free_next    = free_reg;
        turn_next    = turn_reg;

        if (cfg.restart)
        begin
            state_next = S_CLEAR;
            idx_next   = '0;
            pend_next  = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (idx_reg == LAST)
                    begin
                        state_next = S_IDLE;
                        idx_next   = '0;
                        free_next  = load_free;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_next     = req;
                        rem_next     = signed'(REMW'(req.mem_bytes));
                        page_next    = CNT_W'(1);
                        changed_next = '0;
                        status_next  = ST_DONE;
                        idx_next     = '0;
                        pend_next    = 1'b0;
                        if (req.proc_id == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else if ((req.action == ACT_ALLOC) && (free_reg < req.mem_bytes))
                        begin
                            status_next = ST_REFUSED;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    pend_next  = issue;
                    paddr_next = idx_reg[AW-1:0];
                    if (issue)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    if (claim)
                    begin
                        page_next    = page_reg + 1'b1;
                        changed_next = changed_reg + 1'b1;
                        rem_next     = rem_reg - signed'(REMW'(cfg.page_size));
                        free_next    = free_sub;
                    end
                    if (release_hit)
                    begin
                        changed_next = changed_reg + 1'b1;
                        free_next    = free_add;
                    end
                    if (!issue && !pend_reg)
                    begin
                        state_next = S_DONE;
                        if (req_reg.action == ACT_RELEASE)
                        begin
                            turn_next = turn_reg + SUM_W'(req_reg.now);
                        end
                        else
                        begin
                            turn_next = turn_reg - SUM_W'(req_reg.now);
                        end
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_next = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_CLEAR;
                    idx_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            turn_reg  <= '0;
            free_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            turn_reg  <= turn_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        paddr_reg   <= paddr_next;
        req_reg     <= req_next;
        rem_reg     <= rem_next;
        page_reg    <= page_next;
        changed_reg <= changed_next;
        status_reg  <= status_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.status         = status_reg;
        res.frames_changed = changed_reg;
        res.free_bytes     = free_reg;
        res.turnaround_sum = signed'(turn_reg);
    end

endmodule

@@ design/page_frame_allocator_unit.sv @@
// Top level of the page frame allocator: ports, configuration registers, result register.
//
// Channel  Direction  Handshake          Carries
// s_*      in         s_tvalid/s_tready  request word: action, id, bytes, tick
// m_*      out        m_tvalid/m_tready  result word: status, frames, free, sum
// cfg_*    in         cfg_valid/cfg_ready register write: index, data
//
// A request is worked by a scan over the N frames in use: one table entry is read per cycle
// through the single read port and written back in the following cycle. A reserved id or a
// refused allocate skips the scan. After reset and after each write to a listed register, a
// clearing pass empties the table while no request is taken. A finished result waits in the
// output register, so the next request is taken while the sink stalls.
module page_frame_allocator_unit
    import pfa_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Request stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: proc_id[7:0], mem_bytes[25:8], now[42:26], zero pad.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Fields from bit 0: action.
    input  logic                  s_tuser,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: frames_changed[6:0], free_bytes[24:7],
    // turnaround_sum[56:25], zero pad.
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Fields from bit 0: status.
    output logic                  m_tuser,
    // Register writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PSZ_W-1:0]      cfg_data
);

    localparam int OUT_PAD = OUT_DATA_W - (SUM_W + BYTES_W + CNT_W);

    logic [PSZ_W-1:0] page_size_reg, page_size_next;
    logic [CNT_W-1:0] frame_count_reg, frame_count_next;
    logic             m_valid_reg, m_valid_next;
    pfa_res_t         m_res_reg, m_res_next;

    logic     cfg_hit;
    pfa_cfg_t cfg;
    pfa_req_t req;
    logic     res_valid;
    logic     res_ready;
    pfa_res_t res;

    // Register writes are always taken; a write to a listed register also
    // restarts the clearing pass of the table.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        page_size_next   = page_size_reg;
        frame_count_next = frame_count_reg;
        cfg_hit          = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PAGE_SIZE:
                begin
                    page_size_next = cfg_data;
                    cfg_hit        = 1'b1;
                end
                REG_FRAME_COUNT:
                begin
                    frame_count_next = cfg_data[CNT_W-1:0];
                    cfg_hit          = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Frame counts beyond the table depth act as the depth itself.
    always_comb
    begin
        cfg.restart   = cfg_hit;
        cfg.page_size = page_size_reg;
        if (int'(frame_count_reg) > FRAMES)
        begin
            cfg.active_frames = CNT_W'(FRAMES);
        end
        else
        begin
            cfg.active_frames = frame_count_reg;
        end
    end

    always_comb
    begin
        req.action    = s_tuser;
        req.proc_id   = s_tdata[ID_W-1:0];
        req.mem_bytes = s_tdata[ID_W+BYTES_W-1:ID_W];
        req.now       = s_tdata[ID_W+BYTES_W+NOW_W-1:ID_W+BYTES_W];
    end

    pfa_engine #(
        .FRAMES (FRAMES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: it takes a new result whenever it is empty or its
    // word leaves in the same cycle.
    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg   <= PAGE_SIZE_RST;
            frame_count_reg <= FRAME_COUNT_RST;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            page_size_reg   <= page_size_next;
            frame_count_reg <= frame_count_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {{OUT_PAD{1'b0}}, m_res_reg.turnaround_sum,
                       m_res_reg.free_bytes, m_res_reg.frames_changed};

endmodule

@@ design/pfa_checker.sv @@
// Port-level checks of the page frame allocator and their binding to the top level.
`include "page_frame_allocator_unit_assert.svh"

module pfa_checker
    import pfa_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [PSZ_W-1:0]      cfg_data
);

    // A stalled result word holds.
    `PFA_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // During reset nothing is offered and nothing is taken.
    `PFA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_tvalid && !s_tready, "handshake active in reset")

    // Requests are worked one at a time.
    `PFA_ASSERT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

    // A refused allocate claims no frame.
    `PFA_ASSERT(a_refused_zero, clk, rst_n, m_tvalid && m_tuser |-> m_tdata[CNT_W-1:0] == '0, "refused result reports frames")

    // A write to a listed register starts the clearing pass, which blocks requests.
    `PFA_ASSERT(a_cfg_clears, clk, rst_n, cfg_valid && cfg_ready && (cfg_index == REG_PAGE_SIZE || cfg_index == REG_FRAME_COUNT) |=> !s_tready, "request taken during clearing")

endmodule

bind page_frame_allocator_unit pfa_checker u_pfa_checker (.*);

@@ test/page_frame_allocator_unit_tb.sv @@
// Self-checking testbench of the page frame allocator: directed, register and random traffic.
module page_frame_allocator_unit_tb;
    import pfa_pkg::*;

    // An index outside the register list; a write to it must leave everything alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNLISTED = 8'hFF;
    localparam int IN_PAD_W = IN_DATA_W - NOW_W - BYTES_W - ID_W;
    localparam int MAX_BYTES = 262143;
    localparam int MAX_TICK = 131071;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [PSZ_W-1:0]      cfg_data;

    page_frame_allocator_unit #(
        .FRAMES(FRAMES_DEF)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow copy of the frame table, the counters and the two registers.
    logic [ID_W-1:0]  shadow_owner [FRAMES_DEF];
    logic [CNT_W-1:0] shadow_page [FRAMES_DEF];
    int unsigned      free_left;
    logic [SUM_W-1:0] turn_sum;
    logic [PSZ_W-1:0] cur_page_size;
    logic [CNT_W-1:0] cur_frame_count;

    // Result words owed by the block, oldest first.
    pfa_res_t alloc_outcomes [$];
    pfa_res_t want;
    int       mismatch_count;
    bit       no_idle;
    int       rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("[page_frame_allocator_unit] ERROR");
        $finish;
    end

    // Number of frames the table really uses: anything above the depth acts as the depth.
    function automatic int unsigned frames_in_use();
        return (cur_frame_count > FRAMES_DEF) ? FRAMES_DEF : cur_frame_count;
    endfunction

    // Every write to a listed register, and reset, empties the table and refills the free count.
    function automatic void reload_table();
        int unsigned total;
        for (int i = 0; i < FRAMES_DEF; i++)
        begin
            shadow_owner[i] = '0;
            shadow_page[i]  = '0;
        end
        total = frames_in_use() * cur_page_size;
        free_left = (total > FREE_MAX) ? FREE_MAX : total;
    endfunction

    // Works out the result word of one request and updates the shadow state.
    function automatic pfa_res_t allocate_or_release(input pfa_req_t r);
        pfa_res_t    res;
        int unsigned n;
        int unsigned changed;
        int unsigned page_no;
        longint      left;
        int          i;
        n = frames_in_use();
        changed = 0;
        res.status = ST_DONE;
        if (r.proc_id != '0)
        begin
            if (r.action == ACT_ALLOC)
            begin
                if (free_left >= r.mem_bytes)
                begin
                    // Claim free frames from the bottom until the bytes are covered.
                    left = longint'(r.mem_bytes);
                    page_no = 1;
                    for (i = 0; i < n && left > 0; i++)
                    begin
                        if (shadow_owner[i] == '0)
                        begin
                            shadow_owner[i] = r.proc_id;
                            shadow_page[i]  = CNT_W'(page_no);
                            page_no++;
                            changed++;
                            left -= longint'(cur_page_size);
                            free_left = (free_left >= cur_page_size)
                                      ? free_left - cur_page_size : 0;
                        end
                    end
                    turn_sum = turn_sum - r.now;
                end
                else
                begin
                    res.status = ST_REFUSED;
                end
            end
            else
            begin
                for (i = 0; i < n; i++)
                begin
                    if (shadow_owner[i] == r.proc_id)
                    begin
                        shadow_owner[i] = '0;
                        shadow_page[i]  = '0;
                        changed++;
                        free_left += cur_page_size;
                        if (free_left > FREE_MAX)
                            free_left = FREE_MAX;
                    end
                end
                turn_sum = turn_sum + r.now;
            end
        end
        res.frames_changed = CNT_W'(changed);
        res.free_bytes     = BYTES_W'(free_left);
        res.turnaround_sum = turn_sum;
        return res;
    endfunction

    // Sends one request word, with an optional gap in front, and books its result.
    task automatic send_request(input logic act, input int unsigned id,
                                input int unsigned bytes, input int unsigned tick);
        pfa_req_t r;
        r.action    = act;
        r.proc_id   = ID_W'(id);
        r.mem_bytes = BYTES_W'(bytes);
        r.now       = NOW_W'(tick);
        if (!no_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 16)) @(negedge clk);
        s_tdata  = {{IN_PAD_W{1'b0}}, r.now, r.mem_bytes, r.proc_id};
        s_tuser  = r.action;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        alloc_outcomes = {alloc_outcomes, allocate_or_release(r)};
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Writes one register and mirrors its effect on the shadow state.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [PSZ_W-1:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_PAGE_SIZE)
        begin
            cur_page_size = value;
            reload_table();
        end
        else if (idx == REG_FRAME_COUNT)
        begin
            cur_frame_count = value[CNT_W-1:0];
            reload_table();
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Registers are only touched once every owed result word has come back.
    task automatic wait_idle();
        while (alloc_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    // Requests in the reset setting: zero size, refusal, reserved id, exact fit, holes.
    task automatic test_basic_requests();
        send_request(ACT_ALLOC, 1, 0, 0);
        send_request(ACT_ALLOC, 255, MAX_BYTES, MAX_TICK);
        send_request(ACT_ALLOC, 0, 500, 77);
        send_request(ACT_ALLOC, 1, 250, 10);
        // Takes exactly what is left, so the free count ends at zero.
        send_request(ACT_ALLOC, 128, 6100, 20);
        send_request(ACT_ALLOC, 2, 1, 30);
        send_request(ACT_RELEASE, 0, 0, 40);
        send_request(ACT_RELEASE, 1, MAX_BYTES, MAX_TICK);
        send_request(ACT_RELEASE, 77, 0, 50);
        // Refills the three frames that the release above opened at the bottom.
        send_request(ACT_ALLOC, 3, 300, 60);
        send_request(ACT_RELEASE, 128, 0, 70);
        send_request(ACT_RELEASE, 3, 0, 80);
    endtask

    // Register extremes: zero page size, no frames, oversized and masked frame counts.
    task automatic test_register_extremes();
        wait_idle();
        write_register(REG_PAGE_SIZE, 12'd0);
        send_request(ACT_ALLOC, 5, 0, 100);
        send_request(ACT_ALLOC, 5, 1, 101);
        send_request(ACT_RELEASE, 5, 0, 102);
        wait_idle();
        write_register(REG_PAGE_SIZE, 12'd1);
        write_register(REG_FRAME_COUNT, 12'd0);
        send_request(ACT_ALLOC, 6, 0, 103);
        send_request(ACT_ALLOC, 6, 1, 104);
        wait_idle();
        // Only the low seven bits count, and 127 behaves as the full table.
        write_register(REG_PAGE_SIZE, 12'd4095);
        write_register(REG_FRAME_COUNT, 12'hFFF);
        send_request(ACT_ALLOC, 9, 262080, 105);
        send_request(ACT_RELEASE, 9, 0, 106);
        send_request(ACT_ALLOC, 10, MAX_BYTES, 107);
        wait_idle();
        write_register(REG_FRAME_COUNT, 12'd1);
        send_request(ACT_ALLOC, 4, 4095, 108);
        send_request(ACT_ALLOC, 6, 1, 109);
        wait_idle();
        // The table must survive a write to an unknown index.
        write_register(REG_UNLISTED, 12'hFFF);
        send_request(ACT_RELEASE, 4, 0, 110);
    endtask

    // Random traffic over several register settings; the last phase runs without idling.
    task automatic test_random_traffic();
        int unsigned sel;
        int unsigned hi;
        int unsigned bytes;
        logic [PSZ_W-1:0] psz;
        logic [PSZ_W-1:0] fcnt;
        for (int phase = 0; phase < 9; phase++)
        begin
            wait_idle();
            case ($urandom_range(0, 5))
                0: psz = 12'd1;
                1: psz = 12'd4095;
                default: psz = PSZ_W'($urandom_range(1, 4095));
            endcase
            case ($urandom_range(0, 5))
                0: fcnt = 12'd1;
                1: fcnt = PSZ_W'($urandom_range(65, 127));
                2: fcnt = 12'd64;
                default: fcnt = PSZ_W'($urandom_range(2, 64));
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_register(REG_PAGE_SIZE, psz);
                write_register(REG_FRAME_COUNT, fcnt);
            end
            else
            begin
                write_register(REG_FRAME_COUNT, fcnt);
                write_register(REG_PAGE_SIZE, psz);
            end
            if (phase == 8)
                no_idle = 1'b1;
            for (int k = 0; k < 115; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                begin
                    // Reserved id with arbitrary content.
                    send_request(1'($urandom_range(0, 1)), 0, $urandom_range(0, MAX_BYTES),
                                 $urandom_range(0, MAX_TICK));
                end
                else if (sel < 20)
                begin
                    send_request(1'($urandom_range(0, 1)), $urandom_range(1, 255),
                                 $urandom_range(0, MAX_BYTES), $urandom_range(0, MAX_TICK));
                end
                else if (sel < 58)
                begin
                    // Allocations from a small id pool so that releases find owners.
                    case ($urandom_range(0, 3))
                        0: bytes = $urandom_range(0, cur_page_size * 2);
                        1: bytes = $urandom_range(0, free_left);
                        2:
                        begin
                            hi = free_left + cur_page_size;
                            if (hi > MAX_BYTES)
                                hi = MAX_BYTES;
                            bytes = $urandom_range(free_left, hi);
                        end
                        default: bytes = $urandom_range(0, free_left / 4);
                    endcase
                    send_request(ACT_ALLOC, $urandom_range(1, 12), bytes,
                                 $urandom_range(0, MAX_TICK));
                end
                else
                begin
                    send_request(ACT_RELEASE, $urandom_range(1, 12),
                                 $urandom_range(0, MAX_BYTES), $urandom_range(0, MAX_TICK));
                end
            end
        end
    endtask

    // Result side: the sink stalls in random bursts until the final phase.
    initial
    begin
        m_tready = 1'b0;
        rx_hold  = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold == 0)
            begin
                if (no_idle)
                begin
                    m_tready = 1'b1;
                    rx_hold  = 1;
                end
                else
                begin
                    m_tready = ($urandom_range(0, 2) != 0);
                    rx_hold  = $urandom_range(1, 16);
                end
            end
            rx_hold--;
        end
    end

    // Every accepted result word is compared with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (alloc_outcomes.size() == 0)
            begin
                $error("result word with nothing owed: %h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = alloc_outcomes.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[6:0] !== want.frames_changed)
                begin
                    $error("frames_changed: expected %0d, got %0d",
                           want.frames_changed, m_tdata[6:0]);
                    mismatch_count++;
                end
                if (m_tdata[24:7] !== want.free_bytes)
                begin
                    $error("free_bytes: expected %0d, got %0d", want.free_bytes, m_tdata[24:7]);
                    mismatch_count++;
                end
                if (m_tdata[56:25] !== want.turnaround_sum)
                begin
                    $error("turnaround_sum: expected %0d, got %0d",
                           want.turnaround_sum, $signed(m_tdata[56:25]));
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        cur_page_size   = PAGE_SIZE_RST;
        cur_frame_count = FRAME_COUNT_RST;
        turn_sum        = '0;
        reload_table();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_requests();
        test_register_extremes();
        test_random_traffic();

        // Drain, then give a stray word time to show up.
        while (alloc_outcomes.size() != 0)
            @(posedge clk);
        repeat (2 * FRAMES_DEF) @(posedge clk);
        if (mismatch_count == 0 && alloc_outcomes.size() == 0)
            $display("[page_frame_allocator_unit] OK");
        else
            $display("[page_frame_allocator_unit] ERROR");
        $finish;
    end

endmodule
